@@ src/rgb_to_hsi_pixel_top_assert.svh @@
// Assertion macros used by the top level of the pixel converter.
`ifndef RGB_TO_HSI_PIXEL_TOP_ASSERT_SVH
`define RGB_TO_HSI_PIXEL_TOP_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define HSI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ src/hsi_pkg.sv @@
// Package with constants and the arctangent table of the conversion.
package hsi_pkg;
    localparam int CordicIters = 16;
    localparam int ZW = 18;
    localparam int XW = 28;
    localparam int DivSteps = 16;
    localparam logic [ZW-1:0] HueHalf = 18'sd32768;
    localparam logic [14:0] Sqrt3Q14 = 15'd28378;

    function automatic logic [ZW-1:0] atan_entry(input logic [3:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            4'd0: v = 18'd8192;
            4'd1: v = 18'd4836;
            4'd2: v = 18'd2555;
            4'd3: v = 18'd1297;
            4'd4: v = 18'd651;
            4'd5: v = 18'd326;
            4'd6: v = 18'd163;
            4'd7: v = 18'd81;
            4'd8: v = 18'd41;
            4'd9: v = 18'd20;
            4'd10: v = 18'd10;
            4'd11: v = 18'd5;
            4'd12: v = 18'd3;
            4'd13: v = 18'd1;
            4'd14: v = 18'd1;
            default: v = 18'd0;
        endcase
        return v;
    endfunction
endpackage

@@ src/rgb_to_hsi_pixel_top.sv @@
// Top level of the pipelined RGB to HSI pixel converter.
// Usage: present blue, green, red with valid; the item is taken when valid
// and ready are high together. Results appear on hue, saturation and
// intensity with valid and are held until ready is seen high.
// The pipeline accepts one item per cycle while the receiver does not
// stall; it has one stage for setup, sixteen CORDIC stages that also
// carry a restoring divider for saturation (one quotient bit per stage),
// and two stages for clamping and scaling.
// The whole pipeline advances only when its last stage is empty or taken,
// so a stalled receiver stops every stage; nothing is lost or repeated.
// in_ready is high whenever the pipeline can advance.
// Reset clears all valid bits; no item is in flight after reset.
// Intensity is sum/3 by reciprocal multiply; hue scaling uses a
// multiply by 255 and a shift by 16.
// Registers hold payload without reset; only valid bits are reset.
// There is no configuration port.
module rgb_to_hsi_pixel_top
    import hsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] blue,
    input  logic [7:0] green,
    input  logic [7:0] red,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] intensity
);
    `include "rgb_to_hsi_pixel_top_assert.svh"

    localparam int NS = CordicIters + 1;

    logic                  adv;
    logic [NS+1:0]         v_reg;
    logic signed [XW-1:0]  x_reg [NS];
    logic signed [XW-1:0]  y_reg [NS];
    logic signed [ZW-1:0]  z_reg [NS];
    logic [1:0]            cls_reg [NS];
    logic [9:0]            sum_reg [NS];
    logic [7:0]            int_reg [NS];
    logic [16:0]           rem_reg [NS];
    logic [15:0]           quo_reg [NS];
    logic signed [XW-1:0]  xn [CordicIters];
    logic signed [XW-1:0]  yn [CordicIters];
    logic signed [ZW-1:0]  zn [CordicIters];

    logic signed [ZW-1:0]  zc_reg;
    logic [7:0]            sat_f_reg;
    logic [7:0]            int_f_reg;
    logic [7:0]            hue_reg;
    logic [7:0]            sat_reg;
    logic [7:0]            ity_reg;

    logic signed [10:0] xs;
    logic signed [9:0]  ys;
    logic [9:0]         sum_next;
    logic [7:0]         mn;
    logic [9:0]         num;
    logic [1:0]         cls_next;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [ZW-1:0] z0;
    logic [19:0]        int_mul;
    logic [17:0]        num_s;

    assign adv = !v_reg[NS+1] || out_ready;
    assign in_ready = adv;

    // cls: 0 hue zero, 1 g>b, 2 g<b, 3 g==b with hue at half a turn
    always_comb
    begin
        xs = 11'(2 * {1'b0, red}) - 11'(green) - 11'(blue);
        ys = 10'(green) - 10'(blue);
        sum_next = 10'(red) + 10'(green) + 10'(blue);
        mn = blue;
        if (green < mn) mn = green;
        if (red < mn) mn = red;
        num = sum_next - 10'(3 * mn);
        int_mul = 20'(sum_next) * 20'd683;
        if (green > blue) cls_next = 2'd1;
        else if (green < blue) cls_next = 2'd2;
        else cls_next = 2'd3;
        x0 = XW'(xs) <<< 14;
        y0 = XW'(ys) * $signed(XW'(Sqrt3Q14));
        z0 = '0;
        if (xs < 0)
        begin
            z0 = (ys >= 0) ? HueHalf : -HueHalf;
            x0 = -x0;
            y0 = -y0;
        end
        num_s = 18'(num) * 18'd255;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= z0;
            cls_reg[0] <= (ys == 0 && xs >= 0) ? 2'd0 : cls_next;
            sum_reg[0] <= sum_next;
            int_reg[0] <= 8'(int_mul >> 11);
            rem_reg[0] <= 17'(num_s >> 16);
            quo_reg[0] <= num_s[15:0];
        end
    end

    // Stage k: CORDIC iteration k and one restoring division step.
    genvar k;
    generate
        for (k = 0; k < CordicIters; k++)
        begin : g_stage
            logic [16:0] trial;
            logic [16:0] rem_sh;
            hsi_cordic_stage #(.Shift(k)) u_it (
                .x_in(x_reg[k]), .y_in(y_reg[k]), .z_in(z_reg[k]),
                .x_out(xn[k]), .y_out(yn[k]), .z_out(zn[k])
            );
            // The remainder register holds the partial remainder; the quotient
            // register shifts the remaining numerator bits out at the top and
            // takes quotient bits in at the bottom.
            always_comb
            begin
                rem_sh = {rem_reg[k][15:0], quo_reg[k][15]};
                trial = rem_sh - 17'(sum_reg[k]);
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[k+1] <= xn[k];
                    y_reg[k+1] <= yn[k];
                    z_reg[k+1] <= zn[k];
                    cls_reg[k+1] <= cls_reg[k];
                    sum_reg[k+1] <= sum_reg[k];
                    int_reg[k+1] <= int_reg[k];
                    if (!trial[16])
                    begin
                        rem_reg[k+1] <= trial;
                        quo_reg[k+1] <= {quo_reg[k][14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k+1] <= rem_sh;
                        quo_reg[k+1] <= {quo_reg[k][14:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    logic signed [ZW-1:0] zcl;
    logic [25:0]          hmul;

    always_comb
    begin
        zcl = z_reg[NS-1];
        unique case (cls_reg[NS-1])
            2'd0: zcl = '0;
            2'd1:
            begin
                if (zcl < 0) zcl = '0;
                if (zcl > $signed(HueHalf)) zcl = HueHalf;
            end
            2'd2:
            begin
                if (zcl > 0) zcl = '0;
                if (zcl < -$signed(HueHalf)) zcl = -HueHalf;
            end
            default: zcl = HueHalf;
        endcase
        hmul = 26'(zc_reg[15:0]) * 26'd255;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zc_reg <= zcl;
            sat_f_reg <= (sum_reg[NS-1] == 0) ? 8'd0 : quo_reg[NS-1][7:0];
            int_f_reg <= int_reg[NS-1];
            hue_reg <= 8'(hmul >> 16);
            sat_reg <= sat_f_reg;
            ity_reg <= int_f_reg;
        end
    end

    assign out_valid = v_reg[NS+1];
    assign hue = hue_reg;
    assign saturation = sat_reg;
    assign intensity = ity_reg;

    `HSI_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(hue))
    `HSI_ASSERT_IMPL(a_ready, !out_valid, in_ready)
    `HSI_ASSERT_IMPL(a_hue_rng, out_valid, hue != 8'd255)
endmodule

@@ src/hsi_cordic_stage.sv @@
// One CORDIC vectoring iteration with fixed shift.
module hsi_cordic_stage
    import hsi_pkg::*;
#(
    parameter int Shift = 0
) (
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;

    assign dx = y_in >>> Shift;
    assign dy = x_in >>> Shift;
    assign da = atan_entry(4'(Shift));

    always_comb
    begin
        if (y_in >= 0)
        begin
            x_out = x_in + dx;
            y_out = y_in - dy;
            z_out = z_in + da;
        end
        else
        begin
            x_out = x_in - dx;
            y_out = y_in + dy;
            z_out = z_in - da;
        end
    end
endmodule
